FILE: design/assert_macros.svh
// Assertion macros shared by the checker files.
// Clocked on i_clk, switched off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property with a message.
`define CHK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Implication, antecedent and consequent given apart.
`define CHK_IMPLY(label, ante, cons, msg) \
    `CHK_ASSERT(label, (ante) |-> (cons), msg)

`endif

FILE: design/mcpd_pkg.sv
// Shared constants, types and codes for the per-class priority deque.
// No dependencies; used by every module of the block.
package mcpd_pkg;

    localparam int NUM_CLASSES = 16;
    localparam int QUEUE_DEPTH = 8;
    localparam int TAG_WIDTH   = 16;

    // fixed field widths on the ports
    localparam int CLS_W     = 4;
    localparam int IN_TAG_W  = 16;
    localparam int OUT_TAG_W = 16;
    localparam int OUT_CNT_W = 4;
    localparam int CODE_W    = 2;

    // derived widths
    localparam int CIDX_W    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W     = $clog2(2 * QUEUE_DEPTH);
    localparam int MEM_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int ENTRY_W   = TAG_WIDTH + 1;

    // decoupling queue between front and back, power of two deep
    localparam int FQ_DEPTH  = 2;
    localparam int FQ_PTR_W  = $clog2(FQ_DEPTH);
    localparam int FQ_CNT_W  = $clog2(FQ_DEPTH + 1);

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_SERVE = 1'b1
    } t_op;

    typedef enum logic [CODE_W-1:0] {
        RES_DONE  = 2'd0,
        RES_FULL  = 2'd1,
        RES_EMPTY = 2'd2
    } t_code;

    typedef struct packed {
        t_op                  op;
        logic                 cls_ok;
        logic [CIDX_W-1:0]    cls;
        logic                 urgent;
        logic [TAG_WIDTH-1:0] tag;
    } t_item;

endpackage

FILE: design/mcpd_front.sv
// Front end: takes input transfers, decodes the operation, range-checks the class
// and parks the decoded item in a short queue. Depends on mcpd_pkg.
module mcpd_front
    import mcpd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_func,
    input  logic [CLS_W-1:0]    i_class,
    input  logic                i_urgent,
    input  logic [IN_TAG_W-1:0] i_tag,
    output logic                o_item_valid,
    input  logic                i_item_ready,
    output t_item               o_item
);

    t_item                r_fifo [FQ_DEPTH];
    logic [FQ_PTR_W-1:0]  r_wr_ptr;
    logic [FQ_PTR_W-1:0]  r_rd_ptr;
    logic [FQ_CNT_W-1:0]  r_fill;
    t_item                item;
    logic                 push;
    logic                 pop;

    always_comb begin
        item.op     = i_func ? OP_SERVE : OP_ADD;
        item.cls_ok = (32'(i_class) < 32'(NUM_CLASSES));
        item.cls    = CIDX_W'(i_class);
        item.urgent = i_urgent;
        item.tag    = TAG_WIDTH'(i_tag);
    end

    assign o_ready      = (r_fill != FQ_CNT_W'(FQ_DEPTH));
    assign o_item_valid = (r_fill != '0);
    assign o_item       = r_fifo[r_rd_ptr];
    assign push         = i_valid && o_ready;
    assign pop          = o_item_valid && i_item_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= item;
        end
    end

endmodule

FILE: design/mcpd_back.sv
// Back end: per-class head pointers and counts, the entry store, and the result register.
// Depends on mcpd_pkg.
module mcpd_back
    import mcpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_item_valid,
    output logic                 o_item_ready,
    input  t_item                i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_code                o_code,
    output logic [OUT_TAG_W-1:0] o_tag,
    output logic                 o_urgent,
    output logic [OUT_CNT_W-1:0] o_count
);

    typedef enum logic {
        S_IDLE,
        S_SERVE
    } t_state;

    t_state               r_state;
    logic [CNT_W-1:0]     r_cnt  [NUM_CLASSES];
    logic [PTR_W-1:0]     r_head [NUM_CLASSES];
    logic [ENTRY_W-1:0]   r_mem  [MEM_DEPTH];
    logic [ENTRY_W-1:0]   r_rd_data;
    logic [CNT_W-1:0]     r_srv_cnt;
    logic                 r_out_valid;
    t_code                r_out_code;
    logic [OUT_TAG_W-1:0] r_out_tag;
    logic                 r_out_urg;
    logic [OUT_CNT_W-1:0] r_out_cnt;

    logic                 out_free;
    logic                 take;
    logic [CNT_W-1:0]     cur_cnt;
    logic [PTR_W-1:0]     cur_head;
    logic                 full;
    logic                 empty;
    logic [SUM_W-1:0]     tail_sum;
    logic [PTR_W-1:0]     tail;
    logic [PTR_W-1:0]     head_dec;
    logic [PTR_W-1:0]     head_inc;
    logic [ADDR_W-1:0]    base;
    logic                 do_add;
    logic                 do_serve;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [ADDR_W-1:0]    mem_raddr;

    assign out_free     = !r_out_valid || i_ready;
    assign o_item_ready = (r_state == S_IDLE) && out_free;
    assign take         = i_item_valid && o_item_ready;

    assign cur_cnt  = r_cnt[i_item.cls];
    assign cur_head = r_head[i_item.cls];
    assign full     = (cur_cnt >= CNT_W'(QUEUE_DEPTH));
    assign empty    = (cur_cnt == '0);

    // circular slot arithmetic, one compare-and-subtract
    assign tail_sum = SUM_W'(cur_head) + SUM_W'(cur_cnt);
    assign tail     = (tail_sum >= SUM_W'(QUEUE_DEPTH))
                    ? PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
    assign head_dec = (cur_head == '0) ? PTR_W'(QUEUE_DEPTH - 1) : cur_head - 1'b1;
    assign head_inc = (cur_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : cur_head + 1'b1;

    assign base      = ADDR_W'(i_item.cls) * ADDR_W'(QUEUE_DEPTH);
    assign mem_waddr = base + ADDR_W'(i_item.urgent ? head_dec : tail);
    assign mem_raddr = base + ADDR_W'(cur_head);

    assign do_add   = take && i_item.cls_ok && (i_item.op == OP_ADD) && !full;
    assign do_serve = take && i_item.cls_ok && (i_item.op == OP_SERVE) && !empty;

    always_ff @(posedge i_clk) begin
        if (do_add) begin
            r_mem[mem_waddr] <= {i_item.urgent, i_item.tag};
        end
        if (do_serve) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_cnt[i]  <= '0;
                r_head[i] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (take) begin
                        if (do_serve) begin
                            r_cnt[i_item.cls]  <= cur_cnt - 1'b1;
                            r_head[i_item.cls] <= head_inc;
                            r_srv_cnt          <= cur_cnt - 1'b1;
                            r_state            <= S_SERVE;
                            r_out_valid        <= 1'b0;
                        end else begin
                            r_out_valid <= 1'b1;
                            r_out_tag   <= '0;
                            r_out_urg   <= 1'b0;
                            if (!i_item.cls_ok) begin
                                r_out_code <= (i_item.op == OP_SERVE) ? RES_EMPTY : RES_FULL;
                                r_out_cnt  <= '0;
                            end else if (i_item.op == OP_SERVE) begin
                                r_out_code <= RES_EMPTY;
                                r_out_cnt  <= '0;
                            end else if (full) begin
                                r_out_code <= RES_FULL;
                                r_out_cnt  <= OUT_CNT_W'(cur_cnt);
                            end else begin
                                r_cnt[i_item.cls] <= cur_cnt + 1'b1;
                                if (i_item.urgent) begin
                                    r_head[i_item.cls] <= head_dec;
                                end
                                r_out_code <= RES_DONE;
                                r_out_cnt  <= OUT_CNT_W'(cur_cnt + 1'b1);
                            end
                        end
                    end else if (i_ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_SERVE: begin
                    // result register was drained when the serve was taken
                    r_out_valid <= 1'b1;
                    r_out_code  <= RES_DONE;
                    r_out_tag   <= OUT_TAG_W'(r_rd_data[TAG_WIDTH-1:0]);
                    r_out_urg   <= r_rd_data[TAG_WIDTH];
                    r_out_cnt   <= OUT_CNT_W'(r_srv_cnt);
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid  = r_out_valid;
    assign o_code   = r_out_code;
    assign o_tag    = r_out_tag;
    assign o_urgent = r_out_urg;
    assign o_count  = r_out_cnt;

endmodule

FILE: design/multi_class_priority_deque.sv
// Per-class bounded deque. An add passes through the front queue and the result register;
// a serve also passes the registered entry-store read. Throughput: one add per cycle while
// the result stream does not stall; a serve holds the back end in its serve state, so no
// new item is taken until its result is registered. Reset (i_rst_n low, synchronous) empties
// every class and the front queue; the entry store itself is not cleared.
// Depends on mcpd_pkg, mcpd_front and mcpd_back.
module multi_class_priority_deque
    import mcpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [3:0] class_index, [4] urgent, [20:5] tag, rest zero
    input  logic        s_axis_tuser,   // [0] func: 0 add, 1 serve
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] served_tag, [16] served_urgent,
                                        // [20:17] class_count, rest zero
    output logic [1:0]  m_axis_tuser    // [1:0] result_code
);

    // front end decodes transfers into items; the back end executes them.
    // The queue inside the front end lets either side stall on its own.
    logic                 item_valid;
    logic                 item_ready;
    t_item                item;
    t_code                res_code;
    logic [OUT_TAG_W-1:0] res_tag;
    logic                 res_urg;
    logic [OUT_CNT_W-1:0] res_cnt;

    mcpd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_func       (s_axis_tuser),
        .i_class      (s_axis_tdata[CLS_W-1:0]),
        .i_urgent     (s_axis_tdata[CLS_W]),
        .i_tag        (s_axis_tdata[CLS_W+IN_TAG_W:CLS_W+1]),
        .o_item_valid (item_valid),
        .i_item_ready (item_ready),
        .o_item       (item)
    );

    // back end: per-class ring of QUEUE_DEPTH slots. Regular adds write at
    // head+count, urgent adds step the head back and write there, serves read
    // the head slot and step it forward.
    mcpd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .o_item_ready (item_ready),
        .i_item       (item),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_code       (res_code),
        .o_tag        (res_tag),
        .o_urgent     (res_urg),
        .o_count      (res_cnt)
    );

    assign m_axis_tdata = {3'b000, res_cnt, res_urg, res_tag};
    assign m_axis_tuser = res_code;

endmodule

FILE: design/mcpd_checker.sv
// Port-level checks for the per-class deque, bound to the top level.
// Depends on mcpd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mcpd_checker
    import mcpd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    logic        out_stall;
    logic        out_fail;
    logic        out_empty;
    logic        out_range_ok;
    logic [25:0] out_bus;
    logic [16:0] out_entry;
    logic [3:0]  out_cnt;

    assign out_stall    = m_axis_tvalid && !m_axis_tready;
    assign out_fail     = m_axis_tvalid && (m_axis_tuser != RES_DONE);
    assign out_empty    = m_axis_tvalid && (m_axis_tuser == RES_EMPTY);
    assign out_bus      = {m_axis_tuser, m_axis_tdata};
    assign out_entry    = m_axis_tdata[16:0];
    assign out_cnt      = m_axis_tdata[20:17];
    assign out_range_ok = (32'(out_cnt) <= QUEUE_DEPTH) && (m_axis_tuser != 2'd3);

    // a stalled result stays put
    `CHK_IMPLY(a_out_hold, out_stall, ##1 (m_axis_tvalid && $stable(out_bus)), "result not held")

    // refused or empty results carry no served entry
    `CHK_IMPLY(a_no_entry, out_fail, out_entry == 17'd0, "served entry on failed operation")

    // an empty serve reports an empty class
    `CHK_IMPLY(a_empty_cnt, out_empty, out_cnt == 4'd0, "non-zero count on empty serve")

    // count never beyond the queue depth, code always known
    `CHK_IMPLY(a_cnt_range, m_axis_tvalid, out_range_ok, "count or code out of range")

endmodule

bind multi_class_priority_deque mcpd_checker u_mcpd_checker (.*);

FILE: tb/sv/tb_multi_class_priority_deque.sv
// Self-checking testbench for multi_class_priority_deque: directed table, then random traffic.
// Results are checked against an in-bench model of the per-class deques.
// Depends on mcpd_pkg and the block's RTL only.
module tb_multi_class_priority_deque;
    timeunit 1ns;
    timeprecision 1ps;

    import mcpd_pkg::*;

    localparam int N_RANDOM      = 880;
    localparam int CALM_TAIL     = 120;    // last random items run with no idling
    localparam int HOLD_AT_SENT  = 300;    // transfers sent before the long receiver hold-off
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 200000;

    typedef struct packed {
        t_op                  op;
        logic [CLS_W-1:0]     cls;
        logic                 urg;
        logic [IN_TAG_W-1:0]  tag;
    } t_deque_cmd;

    typedef struct packed {
        t_code                code;
        logic [OUT_TAG_W-1:0] tag;
        logic                 urg;
        logic [OUT_CNT_W-1:0] cnt;
    } t_deque_res;

    // directed row: command plus an optional typed-in expectation
    typedef struct packed {
        t_deque_cmd cmd;
        logic       typed;
        t_deque_res res;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;    // [3:0] class_index, [4] urgent, [20:5] tag, rest zero
    logic        s_axis_tuser;    // [0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;    // [15:0] served_tag, [16] served_urgent, [20:17] class_count
    logic [1:0]  m_axis_tuser;    // [1:0] result_code

    // model of the deques
    logic [ENTRY_W-1:0] class_slots [NUM_CLASSES][QUEUE_DEPTH];
    int unsigned        class_fill  [NUM_CLASSES];

    t_deque_res  pending_results[$];
    t_dir_row    dir_rows[$];
    int unsigned n_sent;
    int unsigned n_fail = 0;
    int unsigned n_cycles = 0;
    bit          calm_tail;
    bit          hold_done = 1'b0;

    multi_class_priority_deque u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Apply one command to the model and return the result it should give.
    // Urgent adds shift the class up and land at the head; serves pop the head.
    function automatic t_deque_res deque_update(input t_deque_cmd c);
        t_deque_res r;
        int unsigned n;
        int i;
        r.code = RES_DONE;
        r.tag  = '0;
        r.urg  = 1'b0;
        n = class_fill[c.cls];
        if (c.op == OP_ADD) begin
            if (n >= QUEUE_DEPTH) begin
                r.code = RES_FULL;
            end else begin
                if (c.urg) begin
                    for (i = n; i > 0; i--)
                        class_slots[c.cls][i] = class_slots[c.cls][i-1];
                    class_slots[c.cls][0] = {1'b1, c.tag};
                end else begin
                    class_slots[c.cls][n] = {1'b0, c.tag};
                end
                n++;
            end
        end else begin
            if (n == 0) begin
                r.code = RES_EMPTY;
            end else begin
                r.tag = class_slots[c.cls][0][TAG_WIDTH-1:0];
                r.urg = class_slots[c.cls][0][TAG_WIDTH];
                for (i = 0; i + 1 < n; i++)
                    class_slots[c.cls][i] = class_slots[c.cls][i+1];
                n--;
            end
        end
        class_fill[c.cls] = n;
        r.cnt = n[OUT_CNT_W-1:0];
        return r;
    endfunction

    task automatic add_row(input t_op op, input int cls, input bit urg, input int tag,
                           input bit typed, input t_code code, input int stag,
                           input bit surg, input int cnt);
        t_dir_row r;
        r.cmd.op   = op;
        r.cmd.cls  = cls[CLS_W-1:0];
        r.cmd.urg  = urg;
        r.cmd.tag  = tag[IN_TAG_W-1:0];
        r.typed    = typed;
        r.res.code = code;
        r.res.tag  = stag[OUT_TAG_W-1:0];
        r.res.urg  = surg;
        r.res.cnt  = cnt[OUT_CNT_W-1:0];
        dir_rows.push_back(r);
    endtask

    // Offer one command after an optional gap, wait for its transfer, then record
    // what should come back. A typed expectation replaces the model's answer.
    task automatic offer_cmd(input t_deque_cmd c, input int gap, input bit typed,
                             input t_deque_res typed_res);
        t_deque_res r;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, c.tag, c.urg, c.cls};
        s_axis_tuser  <= c.op;
        do @(posedge i_clk); while (!s_axis_tready);
        r = deque_update(c);
        pending_results.push_back(typed ? typed_res : r);
        n_sent++;
    endtask

    function automatic int pick_gap();
        if (calm_tail || $urandom_range(0, 3) != 0)
            return 0;
        return $urandom_range(1, 17);
    endfunction

    // receiver side: random stalls, one long hold-off, no stalls in the tail
    initial begin
        m_axis_tready <= 1'b1;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!hold_done && n_sent >= HOLD_AT_SENT) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (!calm_tail && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // result check against the oldest expectation
    t_deque_res exp_res;
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer: tuser %0d tdata %h",
                       m_axis_tuser, m_axis_tdata);
                n_fail++;
            end else begin
                exp_res = pending_results.pop_front();
                if (m_axis_tuser !== exp_res.code) begin
                    $error("result_code: expected %0d, got %0d", exp_res.code, m_axis_tuser);
                    n_fail++;
                end
                if (m_axis_tdata[15:0] !== exp_res.tag) begin
                    $error("served_tag: expected %h, got %h", exp_res.tag, m_axis_tdata[15:0]);
                    n_fail++;
                end
                if (m_axis_tdata[16] !== exp_res.urg) begin
                    $error("served_urgent: expected %0d, got %0d", exp_res.urg, m_axis_tdata[16]);
                    n_fail++;
                end
                if (m_axis_tdata[20:17] !== exp_res.cnt) begin
                    $error("class_count: expected %0d, got %0d", exp_res.cnt,
                           m_axis_tdata[20:17]);
                    n_fail++;
                end
            end
        end
    end

    // main sequence
    initial begin
        t_deque_cmd c;
        t_deque_res none;
        int k;
        int i;
        int mode;
        int add_pct;
        int hot;
        bit focused;

        none = '0;
        n_sent = 0;
        calm_tail = 1'b0;
        for (i = 0; i < NUM_CLASSES; i++)
            class_fill[i] = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty after reset, urgent overtaking, a full class, then draining it
        add_row(OP_SERVE, 0,  0, 16'h1234, 1, RES_EMPTY, 0, 0, 0);
        add_row(OP_SERVE, 15, 1, 16'hFFFF, 1, RES_EMPTY, 0, 0, 0);
        add_row(OP_ADD,   0,  0, 16'hFFFF, 1, RES_DONE,  0, 0, 1);
        add_row(OP_ADD,   0,  1, 16'h0000, 1, RES_DONE,  0, 0, 2);
        add_row(OP_SERVE, 0,  0, 16'h0000, 1, RES_DONE,  16'h0000, 1, 1);
        add_row(OP_SERVE, 0,  0, 16'h0000, 1, RES_DONE,  16'hFFFF, 0, 0);
        add_row(OP_SERVE, 0,  0, 16'h0000, 1, RES_EMPTY, 0, 0, 0);
        for (i = 0; i < QUEUE_DEPTH; i++)
            add_row(OP_ADD, 15, i[0], (16'h0001 << (2 * i)) | 16'h8000, 0, RES_DONE, 0, 0, 0);
        add_row(OP_ADD,   15, 1, 16'hAAAA, 1, RES_FULL,  0, 0, QUEUE_DEPTH);
        for (i = 0; i < QUEUE_DEPTH; i++)
            add_row(OP_SERVE, 15, 0, 16'h5555, 0, RES_DONE, 0, 0, 0);
        add_row(OP_SERVE, 15, 0, 16'h0000, 1, RES_EMPTY, 0, 0, 0);

        foreach (dir_rows[i])
            offer_cmd(dir_rows[i].cmd, pick_gap(), dir_rows[i].typed, dir_rows[i].res);

        // random: phases that lean towards adds, towards serves or stay near even, on two hot classes or all
        mode = 0;
        add_pct = 50;
        hot = 0;
        focused = 1'b0;
        for (k = 0; k < N_RANDOM; k++) begin
            if (k % 60 == 0) begin
                mode    = $urandom_range(0, 2);
                add_pct = (mode == 0) ? 75 : (mode == 1) ? 25 : 52;
                hot     = $urandom_range(0, NUM_CLASSES - 1);
                focused = $urandom_range(0, 2) != 0;
            end
            if (k == N_RANDOM - CALM_TAIL)
                calm_tail = 1'b1;
            c.op  = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_SERVE;
            c.cls = focused ? CLS_W'(hot + $urandom_range(0, 1)) : CLS_W'($urandom_range(0, 15));
            c.urg = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 7))
                0: c.tag = '0;
                1: c.tag = '1;
                default: c.tag = IN_TAG_W'($urandom_range(0, 65535));
            endcase
            offer_cmd(c, pick_gap(), 1'b0, none);
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_fail == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
